// ----- rtl/core/date_countdown_nearest_selector_top_assert.svh -----
// Assertion macros shared by the checker of the countdown selector.
`ifndef DATE_COUNTDOWN_NEAREST_SELECTOR_TOP_ASSERT_SVH
`define DATE_COUNTDOWN_NEAREST_SELECTOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCNS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/dcns_pkg.sv -----
`default_nettype none

package dcns_pkg;

    // Stream and configuration widths.
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 40;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Day numbers and distances.
    localparam int DAY_W  = 26;
    localparam int DIST_W = 25;

    // Calendar constants.
    localparam int ERA_DAYS     = 146097;
    localparam int EPOCH_OFFSET = 719468;
    localparam int YEAR_DAYS    = 365;
    localparam int ERA_YEARS    = 400;
    localparam int MONTH_MAX    = 12;
    localparam int DAY_MAX      = 31;

    // Reciprocal multipliers for division by 400 (17-bit years) and by 100 (9-bit years).
    localparam int DIV400_MUL   = 167773;
    localparam int DIV400_SHIFT = 26;
    localparam int DIV100_MUL   = 656;
    localparam int DIV100_SHIFT = 16;

    // Queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TODAY_YEAR  = 2'd0,
        CFG_TODAY_MONTH = 2'd1,
        CFG_TODAY_DAY   = 2'd2
    } t_cfg_index;

    // Per-record information that rides alongside the date conversion.
    typedef struct packed {
        logic [2:0] slot;
        logic       ok;
        logic       enabled;
        logic       annual;
        logic       in_range;
        logic       last;
        logic [7:0] lead;
    } t_side;

    // Classified record as held in the queue.
    typedef struct packed {
        t_side       side;
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_item;

    // One result.
    typedef struct packed {
        logic                    record_ok;
        logic signed [DAY_W-1:0] days_left;
        logic                    in_window;
        logic                    eligible;
        logic                    winner_found;
        logic [2:0]              winner_slot;
        logic                    scan_done;
    } t_result;

    // Days from March 1st to the first day of the shifted month, (153 * mp + 2) / 5.
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] offs;
        unique case (mp)
            4'd0:    offs = 9'd0;
            4'd1:    offs = 9'd31;
            4'd2:    offs = 9'd61;
            4'd3:    offs = 9'd92;
            4'd4:    offs = 9'd122;
            4'd5:    offs = 9'd153;
            4'd6:    offs = 9'd184;
            4'd7:    offs = 9'd214;
            4'd8:    offs = 9'd245;
            4'd9:    offs = 9'd275;
            4'd10:   offs = 9'd306;
            4'd11:   offs = 9'd337;
            4'd12:   offs = 9'd367;
            default: offs = 9'd0;
        endcase
        return offs;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dcns_front.sv -----
`default_nettype none

module dcns_front #(
    parameter int SLOT_COUNT = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [dcns_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  wire logic                           i_s_tlast,
    input  wire logic [15:0]                    i_today_year,
    output logic                                o_item_valid,
    input  wire logic                           i_item_ready,
    output dcns_pkg::t_item                     o_item
);

    logic            r_valid;
    dcns_pkg::t_item r_item;
    dcns_pkg::t_item n_item;
    logic            accept;

    logic [2:0] slot;
    logic       present;
    logic [7:0] month;
    logic [7:0] day;

    // Unpack the request.
    assign slot    = i_s_tdata[2:0];
    assign present = i_s_tdata[3];
    assign month   = i_s_tdata[29:22];
    assign day     = i_s_tdata[37:30];

    // Classify: range checks on the raw bytes and choice of the conversion year.
    always_comb begin
        n_item.side.slot     = slot;
        n_item.side.ok       = present && (month >= 8'd1)
                               && (month <= 8'(dcns_pkg::MONTH_MAX))
                               && (day >= 8'd1) && (day <= 8'(dcns_pkg::DAY_MAX));
        n_item.side.enabled  = i_s_tdata[4];
        n_item.side.annual   = i_s_tdata[5];
        n_item.side.in_range = 32'(slot) < SLOT_COUNT;
        n_item.side.last     = i_s_tlast;
        n_item.side.lead     = i_s_tdata[45:38];
        n_item.year          = i_s_tdata[5] ? i_today_year : i_s_tdata[21:6];
        n_item.month         = month[3:0];
        n_item.day           = day[4:0];
    end

    assign o_s_tready = !r_valid || i_item_ready;
    assign accept     = i_s_tvalid && o_s_tready;

    // Holding register in front of the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_item_ready) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

`default_nettype wire

// ----- rtl/core/dcns_queue.sv -----
`default_nettype none

module dcns_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire dcns_pkg::t_item i_data,
    output logic                 o_ready,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output dcns_pkg::t_item      o_data
);

    localparam int PTR_W = dcns_pkg::QUEUE_PTR_W;

    dcns_pkg::t_item  r_mem [dcns_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = r_count != (PTR_W+1)'(dcns_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dcns_civil.sv -----
`default_nettype none

// Four-stage days-from-civil conversion; day 0 is 1970-01-01.
module dcns_civil (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic [16:0]                       i_year,
    input  wire logic [3:0]                        i_month,
    input  wire logic [4:0]                        i_day,
    output logic signed [dcns_pkg::DAY_W-1:0]      o_days
);

    localparam int DW = dcns_pkg::DAY_W;

    // Stage one: shift the year to start in March, divide it by 400.
    logic               before_mar;
    logic signed [17:0] y_adj;
    logic [3:0]         mp;
    logic signed [10:0] doy;
    logic [34:0]        prod400;
    logic signed [8:0]  era;

    logic signed [17:0] r_y1;
    logic signed [8:0]  r_era1;
    logic signed [10:0] r_doy1;

    always_comb begin
        before_mar = i_month <= 4'd2;
        y_adj      = $signed({1'b0, i_year}) - $signed(18'(before_mar));
        mp         = before_mar ? (i_month + 4'd9) : (i_month - 4'd3);
        doy        = $signed(11'(dcns_pkg::month_offset(mp))) + $signed(11'(i_day)) - 11'sd1;
        prod400    = 35'(y_adj[16:0]) * 35'(dcns_pkg::DIV400_MUL);
        era        = y_adj[17] ? -9'sd1 : $signed({1'b0, prod400[dcns_pkg::DIV400_SHIFT +: 8]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y1   <= y_adj;
            r_era1 <= era;
            r_doy1 <= doy;
        end
    end

    // Stage two: year of the era.
    logic signed [17:0] yoe_full;
    logic [8:0]         r_yoe2;
    logic signed [8:0]  r_era2;
    logic signed [10:0] r_doy2;

    assign yoe_full = r_y1 - 18'(r_era1) * 18'sd400;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_yoe2 <= yoe_full[8:0];
            r_era2 <= r_era1;
            r_doy2 <= r_doy1;
        end
    end

    // Stage three: day of the era.
    logic [17:0]        prod100;
    logic [1:0]         cent;
    logic [17:0]        doe_base;
    logic signed [18:0] doe;
    logic signed [18:0] r_doe3;
    logic signed [8:0]  r_era3;

    always_comb begin
        prod100  = 18'(r_yoe2) * 18'(dcns_pkg::DIV100_MUL);
        cent     = prod100[dcns_pkg::DIV100_SHIFT +: 2];
        doe_base = 18'(r_yoe2) * 18'(dcns_pkg::YEAR_DAYS) + 18'(r_yoe2 >> 2) - 18'(cent);
        doe      = $signed({1'b0, doe_base}) + 19'(r_doy2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_doe3 <= doe;
            r_era3 <= r_era2;
        end
    end

    // Stage four: whole day number.
    logic signed [DW-1:0] day_num;
    logic signed [DW-1:0] r_days4;

    assign day_num = DW'(r_era3) * $signed(DW'(dcns_pkg::ERA_DAYS)) + DW'(r_doe3)
                     - $signed(DW'(dcns_pkg::EPOCH_OFFSET));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_days4 <= day_num;
        end
    end

    assign o_days = r_days4;

endmodule

`default_nettype wire

// ----- rtl/core/dcns_back.sv -----
`default_nettype none

module dcns_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_item_valid,
    input  wire dcns_pkg::t_item i_item,
    output logic                 o_item_pop,
    input  wire logic [15:0]     i_today_year,
    input  wire logic [3:0]      i_today_month,
    input  wire logic [4:0]      i_today_day,
    output logic                 o_res_valid,
    input  wire logic            i_res_ready,
    output dcns_pkg::t_result    o_res
);

    localparam int DW     = dcns_pkg::DAY_W;
    localparam int DSW    = dcns_pkg::DIST_W;
    localparam int STAGES = 4;

    logic adv;

    logic signed [DW-1:0] today_num;
    logic signed [DW-1:0] target_num;
    logic signed [DW-1:0] next_num;

    logic            r_vld [STAGES];
    dcns_pkg::t_side r_sb  [STAGES];

    logic                 r_d_valid;
    dcns_pkg::t_side      r_d_side;
    logic signed [DW-1:0] r_d_days;

    logic                 r_have;
    logic                 r_best_past;
    logic [DSW-1:0]       r_best_dist;
    logic [2:0]           r_best_idx;

    logic                 r_out_valid;
    dcns_pkg::t_result    r_out;

    // The whole pipeline moves unless a finished result is held up.
    assign adv        = !r_out_valid || i_res_ready;
    assign o_item_pop = adv && i_item_valid;

    // Three conversions: today, the target date, and the target month and day in the year after today's.
    dcns_civil u_today (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_year  ({1'b0, i_today_year}),
        .i_month (i_today_month),
        .i_day   (i_today_day),
        .o_days  (today_num)
    );

    dcns_civil u_target (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_year  ({1'b0, i_item.year}),
        .i_month (i_item.month),
        .i_day   (i_item.day),
        .o_days  (target_num)
    );

    dcns_civil u_next (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_year  (17'(i_today_year) + 17'd1),
        .i_month (i_item.month),
        .i_day   (i_item.day),
        .o_days  (next_num)
    );

    // Record flags travel beside the conversion stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STAGES; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= i_item_valid;
            for (int i = 1; i < STAGES; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
        if (adv) begin
            r_sb[0] <= i_item.side;
            for (int i = 1; i < STAGES; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
        end
    end

    // Days remaining, zero for a rejected record; an annual date that has passed moves to next year.
    logic signed [DW-1:0] diff_this;
    logic signed [DW-1:0] diff_next;
    logic signed [DW-1:0] days;

    always_comb begin
        diff_this = target_num - today_num;
        diff_next = next_num - today_num;
        if (!r_sb[STAGES-1].ok) begin
            days = '0;
        end else if (r_sb[STAGES-1].annual && diff_this[DW-1]) begin
            days = diff_next;
        end else begin
            days = diff_this;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (adv) begin
            r_d_valid <= r_vld[STAGES-1];
        end
        if (adv) begin
            r_d_side <= r_sb[STAGES-1];
            r_d_days <= days;
        end
    end

    // Window test, eligibility and the running choice of the nearest slot.
    logic           neg;
    logic           win;
    logic           elig;
    logic [DW-1:0]  neg_days;
    logic [DSW-1:0] abs_days;
    logic           take;
    logic           n_have;
    logic           n_best_past;
    logic [DSW-1:0] n_best_dist;
    logic [2:0]     n_best_idx;
    dcns_pkg::t_result n_out;

    always_comb begin
        neg      = r_d_days[DW-1];
        neg_days = DW'(-r_d_days);
        abs_days = neg ? neg_days[DSW-1:0] : r_d_days[DSW-1:0];
        win      = r_d_side.ok && ((r_d_side.lead == 8'd0)
                   || (!neg && (r_d_days[DSW-1:0] <= DSW'(r_d_side.lead))));
        elig     = win && r_d_side.enabled && r_d_side.in_range;

        priority if (!r_have) begin
            take = 1'b1;
        end else if (neg != r_best_past) begin
            take = !neg;
        end else begin
            take = abs_days < r_best_dist;
        end

        if (elig && take) begin
            n_have      = 1'b1;
            n_best_past = neg;
            n_best_dist = abs_days;
            n_best_idx  = r_d_side.slot;
        end else begin
            n_have      = r_have;
            n_best_past = r_best_past;
            n_best_dist = r_best_dist;
            n_best_idx  = r_best_idx;
        end

        n_out.record_ok    = r_d_side.ok;
        n_out.days_left    = r_d_days;
        n_out.in_window    = win;
        n_out.eligible     = elig;
        n_out.winner_found = r_d_side.last && n_have;
        n_out.winner_slot  = (r_d_side.last && n_have) ? n_best_idx : 3'd0;
        n_out.scan_done    = r_d_side.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_best_past <= 1'b0;
            r_best_dist <= '0;
            r_best_idx  <= '0;
        end else if (adv && r_d_valid) begin
            if (r_d_side.last) begin
                r_have      <= 1'b0;
                r_best_past <= 1'b0;
                r_best_dist <= '0;
                r_best_idx  <= '0;
            end else begin
                r_have      <= n_have;
                r_best_past <= n_best_past;
                r_best_dist <= n_best_dist;
                r_best_idx  <= n_best_idx;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_d_valid;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

// ----- rtl/core/date_countdown_nearest_selector_top.sv -----
// Countdown to stored occasions. Each request carries one occasion record; the block
// returns one result per record with the signed days from today to the occasion (an
// annual date that has passed counts to next year's), whether it lies in its lead
// window and whether it is eligible, and on the record marked tlast it also reports the
// nearest eligible slot of the scan (future dates before past ones, the first scanned on
// a tie). Today's date is set through the configuration channel (index 0 year, 1 month,
// 2 day), which is always ready and should be written only while no record is in flight.
// One record is taken every clock cycle while the output is not held up; a result passes
// through the input register, the four-entry queue and the four-stage date conversion,
// followed by the difference and selection stages. Output back-pressure stalls the
// conversion pipeline; the queue and input register then absorb up to five more requests.
`default_nettype none

module date_countdown_nearest_selector_top #(
    parameter int SLOT_COUNT = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Records in.
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // slot[2:0], present[3], enabled[4], annual[5], target_year[21:6],
    // target_month[29:22], target_day[37:30], lead[45:38], zero[47:46]
    input  wire logic [dcns_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    input  wire logic                              i_s_axis_tlast,
    // Results out.
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // record_ok[0], days_left[26:1], in_window[27], eligible[28], winner_found[29],
    // winner_slot[32:30], zero[39:33]
    output logic [dcns_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata,
    output logic                                   o_m_axis_tlast,
    // Configuration writes.
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [dcns_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [dcns_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [15:0] r_today_year;
    logic [3:0]  r_today_month;
    logic [4:0]  r_today_day;

    logic              front_valid;
    logic              queue_ready;
    dcns_pkg::t_item   front_item;
    logic              queue_valid;
    dcns_pkg::t_item   queue_item;
    logic              queue_pop;
    dcns_pkg::t_result res;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_today_year  <= 16'd1970;
            r_today_month <= 4'd1;
            r_today_day   <= 5'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dcns_pkg::CFG_TODAY_YEAR:  r_today_year  <= i_cfg_data;
                dcns_pkg::CFG_TODAY_MONTH: r_today_month <= i_cfg_data[3:0];
                dcns_pkg::CFG_TODAY_DAY:   r_today_day   <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    dcns_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .o_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tlast    (i_s_axis_tlast),
        .i_today_year (r_today_year),
        .o_item_valid (front_valid),
        .i_item_ready (queue_ready),
        .o_item       (front_item)
    );

    dcns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_item),
        .o_ready (queue_ready),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_item)
    );

    dcns_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (queue_valid),
        .i_item        (queue_item),
        .o_item_pop    (queue_pop),
        .i_today_year  (r_today_year),
        .i_today_month (r_today_month),
        .i_today_day   (r_today_day),
        .o_res_valid   (o_m_axis_tvalid),
        .i_res_ready   (i_m_axis_tready),
        .o_res         (res)
    );

    // Pack the result.
    assign o_m_axis_tdata = {7'd0, res.winner_slot, res.winner_found, res.eligible,
                             res.in_window, res.days_left, res.record_ok};
    assign o_m_axis_tlast = res.scan_done;

endmodule

`default_nettype wire

// ----- rtl/core/dcns_checker.sv -----
`default_nettype none

`include "date_countdown_nearest_selector_top_assert.svh"

module dcns_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_m_axis_tvalid,
    input wire logic                              i_m_axis_tready,
    input wire logic [dcns_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input wire logic                              o_m_axis_tlast
);

    // A result held back by the sink stays put.
    `DCNS_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast),
        "result changed while stalled")

    // A rejected record reports no days, window or eligibility.
    `DCNS_ASSERT_NOW(a_bad_record_clear, o_m_axis_tvalid && !o_m_axis_tdata[0],
        o_m_axis_tdata[28:1] == 28'd0, "rejected record carries data")

    // Eligibility needs a good record inside its window.
    `DCNS_ASSERT_NOW(a_elig_window, o_m_axis_tvalid && o_m_axis_tdata[28],
        o_m_axis_tdata[27] && o_m_axis_tdata[0], "eligible outside window")

    // Winner fields appear only at the end of a scan, and a slot only with a winner.
    `DCNS_ASSERT_NOW(a_winner_at_end, o_m_axis_tvalid && !(o_m_axis_tlast && o_m_axis_tdata[29]),
        o_m_axis_tdata[32:30] == 3'd0 && (o_m_axis_tlast || !o_m_axis_tdata[29]),
        "winner reported outside end of scan")

endmodule

bind date_countdown_nearest_selector_top dcns_checker u_dcns_checker (.*);

`default_nettype wire
